FILE: hw/rtl/lea_pkg.sv
// package: shared constants, codes, types and the reciprocal rom of the limiter envelope
`timescale 1ns / 1ps
`default_nettype none

package lea_pkg;

  localparam int unsigned ArcEntries = 64;
  localparam int unsigned ArcW       = $clog2(ArcEntries);
  localparam int unsigned AttnW      = 31;
  localparam int unsigned TblW       = 32;
  localparam int unsigned OpW        = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned RomW       = 16;

  localparam logic [AttnW-1:0] FULL31   = 31'h7fffffff;
  localparam logic [TblW-1:0]  COEF_MAX = 32'h7fffffff;
  localparam logic [TblW-1:0]  COEF_MIN = 32'h80000000;
  localparam logic [ArcW-1:0]  ARC_MAX  = 6'h3f;

  // op codes of an input request
  localparam logic [OpW-1:0] OP_SAMPLE    = 2'd0;
  localparam logic [OpW-1:0] OP_WR_HOLD   = 2'd1;
  localparam logic [OpW-1:0] OP_WR_REL    = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_RMS_ATTACK  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RMS_RELEASE = 2'd1;

  typedef struct packed {
    logic             we_hold;
    logic             we_rel;
    logic [ArcW-1:0]  addr;
    logic [TblW-1:0]  data;
  } tbl_wr_t;

  function automatic logic [RomW-1:0] recip_rom(input logic [ArcW-1:0] sel);
    logic [RomW-1:0] v;
    case (sel)
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4,
      6'd5, 6'd6, 6'd7, 6'd8, 6'd9: v = 16'h6000;
      6'd10: v = 16'h5d17;  6'd11: v = 16'h5555;  6'd12: v = 16'h4ec4;
      6'd13: v = 16'h4924;  6'd14: v = 16'h4444;  6'd15: v = 16'h4000;
      6'd16: v = 16'h3c3c;  6'd17: v = 16'h38e3;  6'd18: v = 16'h35e5;
      6'd19: v = 16'h3333;  6'd20: v = 16'h30c3;  6'd21: v = 16'h2e8b;
      6'd22: v = 16'h2c85;  6'd23: v = 16'h2aaa;  6'd24: v = 16'h28f5;
      6'd25: v = 16'h2762;  6'd26: v = 16'h25ed;  6'd27: v = 16'h2492;
      6'd28: v = 16'h234f;  6'd29: v = 16'h2222;  6'd30: v = 16'h2108;
      6'd31: v = 16'h2000;  6'd32: v = 16'h1f07;  6'd33: v = 16'h1e1e;
      6'd34: v = 16'h1d41;  6'd35: v = 16'h1c71;  6'd36: v = 16'h1bac;
      6'd37: v = 16'h1af2;  6'd38: v = 16'h1a41;  6'd39: v = 16'h1999;
      6'd40: v = 16'h18f9;  6'd41: v = 16'h1861;  6'd42: v = 16'h17d0;
      6'd43: v = 16'h1745;  6'd44: v = 16'h16c1;  6'd45: v = 16'h1642;
      6'd46: v = 16'h15c9;  6'd47: v = 16'h1555;  6'd48: v = 16'h14e5;
      6'd49: v = 16'h147a;  6'd50: v = 16'h1414;  6'd51: v = 16'h13b1;
      6'd52: v = 16'h1352;  6'd53: v = 16'h12f6;  6'd54: v = 16'h129e;
      6'd55: v = 16'h1249;  6'd56: v = 16'h11f7;  6'd57: v = 16'h11a7;
      6'd58: v = 16'h115b;  6'd59: v = 16'h1111;  6'd60: v = 16'h10c9;
      6'd61: v = 16'h1084;  6'd62: v = 16'h1041;  6'd63: v = 16'h1000;
      default: v = 16'h1000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lea_mul.sv
// shared signed 32x32 multiplier with registered product
`timescale 1ns / 1ps
`default_nettype none

module lea_mul (
  input  wire                                   clk_i,
  input  wire                                   en_i,
  input  wire logic signed [lea_pkg::TblW-1:0]  a_i,
  input  wire logic signed [lea_pkg::TblW-1:0]  b_i,
  output logic signed [2*lea_pkg::TblW-1:0]     p_o
);
  import lea_pkg::*;

  logic signed [2*TblW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= (2*TblW)'(a_i) * (2*TblW)'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: hw/rtl/lea_tables.sv
// hold and release tables: one write port, registered read at one address
`timescale 1ns / 1ps
`default_nettype none

module lea_tables (
  input  wire                              clk_i,
  input  wire lea_pkg::tbl_wr_t            wr_i,
  input  wire                              rd_en_i,
  input  wire logic [lea_pkg::ArcW-1:0]    rd_addr_i,
  output logic [lea_pkg::TblW-1:0]         hold_o,
  output logic [lea_pkg::TblW-1:0]         rel_o
);
  import lea_pkg::*;

  logic [TblW-1:0] hold_mem [ArcEntries];
  logic [TblW-1:0] rel_mem  [ArcEntries];
  logic [TblW-1:0] hold_q;
  logic [TblW-1:0] rel_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we_hold) begin
      hold_mem[wr_i.addr] <= wr_i.data;
    end
    if (wr_i.we_rel) begin
      rel_mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      hold_q <= hold_mem[rd_addr_i];
      rel_q  <= rel_mem[rd_addr_i];
    end
  end

  assign hold_o = hold_q;
  assign rel_o  = rel_q;

endmodule

`default_nettype wire

FILE: hw/rtl/limiter_envelope_adaptive_release.sv
// top level: sequencer and datapath of the limiter envelope with adaptive release
// sequence: a sample request steps through S_COEF, S_MUL1, S_ENV, S_RMS1, S_MUL2 and S_RMS2
//   to the output register, with two passes through the one shared multiplier; a new sample
//   is taken only when idle again; table writes and ignored ops never leave S_IDLE
// reset: control state, envelope state and coefficients clear at once; the hold and
//   release tables are undefined until written
`timescale 1ns / 1ps
`default_nettype none

module limiter_envelope_adaptive_release (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [lea_pkg::OpW-1:0]       op_i,
  input  wire logic [lea_pkg::AttnW-1:0]     target_attn_i,
  input  wire logic [lea_pkg::ArcW-1:0]      table_index_i,
  input  wire logic signed [lea_pkg::TblW-1:0] table_value_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [lea_pkg::AttnW-1:0]          smoothed_attn_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lea_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [lea_pkg::AttnW-1:0]     cfg_data_i
);
  import lea_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COEF = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_ENV  = 3'd3;
  localparam logic [2:0] S_RMS1 = 3'd4;
  localparam logic [2:0] S_MUL2 = 3'd5;
  localparam logic [2:0] S_RMS2 = 3'd6;

  logic [2:0]              state_q, state_d;
  logic [AttnW-1:0]        atk_coef_q, rel_coef_cfg_q;
  logic [AttnW-1:0]        prev_attn_q, prev_attn_d;
  logic [AttnW-1:0]        rms_q, rms_d;
  logic [ArcW-1:0]         arc_q, arc_d;
  logic signed [TblW-1:0]  rcoef_q, rcoef_d;
  logic [AttnW-1:0]        attn_q, attn_d;
  logic                    rel_q, rel_d;
  logic signed [TblW-1:0]  op_a_q, op_a_d;
  logic signed [TblW-1:0]  op_b_q, op_b_d;
  logic                    out_valid_q, out_valid_d;
  logic [AttnW-1:0]        out_data_q, out_data_d;

  logic                    accept;
  logic                    mul_en;
  logic signed [2*TblW-1:0] prod;
  tbl_wr_t                 tbl_wr;
  logic [TblW-1:0]         hold_rd, rel_rd;

  // combinational helpers
  logic signed [TblW:0]    hold_sum;
  logic signed [TblW-1:0]  c_sat, c_new;
  logic signed [TblW-1:0]  d_signed;
  logic [ArcW-1:0]         sel;
  logic signed [TblW+1:0]  env_sum;
  logic [AttnW-1:0]        env_clamp;
  logic [TblW-1:0]         arc_full;
  logic                    out_free;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign tbl_wr.we_hold = accept && (op_i == OP_WR_HOLD);
  assign tbl_wr.we_rel  = accept && (op_i == OP_WR_REL);
  assign tbl_wr.addr    = table_index_i;
  assign tbl_wr.data    = table_value_i;

  assign mul_en = (state_q == S_MUL1) || (state_q == S_MUL2);

  lea_tables u_tables (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_en_i   (accept),
    .rd_addr_i (arc_q),
    .hold_o    (hold_rd),
    .rel_o     (rel_rd)
  );

  lea_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (op_a_q),
    .b_i   (op_b_q),
    .p_o   (prod)
  );

  always_comb begin
    // hold step, saturated to 32 bits, then floored at the release entry
    hold_sum = {rcoef_q[TblW-1], rcoef_q} + {hold_rd[TblW-1], hold_rd};
    if (hold_sum > $signed({1'b0, COEF_MAX})) begin
      c_sat = COEF_MAX;
    end else if (hold_sum < $signed({1'b1, COEF_MIN})) begin
      c_sat = COEF_MIN;
    end else begin
      c_sat = hold_sum[TblW-1:0];
    end
    c_new = (c_sat < $signed(rel_rd)) ? $signed(rel_rd) : c_sat;

    d_signed = $signed({1'b0, attn_q}) - $signed({1'b0, rms_q});
    sel = (attn_q[AttnW-1:26] != '0) ? ARC_MAX : attn_q[25:20];

    // attn plus floored q31 product, clamped to the output range
    env_sum = $signed({3'b000, attn_q}) + $signed({prod[2*TblW-1], prod[2*TblW-1:31]});
    if (env_sum < 0) begin
      env_clamp = '0;
    end else if (env_sum > $signed({3'b000, FULL31})) begin
      env_clamp = FULL31;
    end else begin
      env_clamp = env_sum[AttnW-1:0];
    end
    arc_full = prod[2*TblW-1:TblW];
  end

  always_comb begin
    state_d     = state_q;
    prev_attn_d = prev_attn_q;
    rms_d       = rms_q;
    arc_d       = arc_q;
    rcoef_d     = rcoef_q;
    attn_d      = attn_q;
    rel_d       = rel_q;
    op_a_d      = op_a_q;
    op_b_d      = op_b_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (op_i == OP_SAMPLE)) begin
          attn_d  = target_attn_i;
          state_d = S_COEF;
        end
      end
      S_COEF: begin
        rel_d = (attn_q < prev_attn_q);
        if (attn_q < prev_attn_q) begin
          rcoef_d = c_new;
          op_a_d  = $signed({1'b0, prev_attn_q - attn_q});
          op_b_d  = c_new;
        end else begin
          rcoef_d = $signed(COEF_MAX);
          op_a_d  = d_signed[TblW-1] ? '0 : d_signed;
          op_b_d  = $signed({{(TblW-RomW){1'b0}}, recip_rom(sel)});
        end
        state_d = S_MUL1;
      end
      S_MUL1: begin
        state_d = S_ENV;
      end
      S_ENV: begin
        if (rel_q) begin
          attn_d      = env_clamp;
          prev_attn_d = env_clamp;
        end else begin
          prev_attn_d = attn_q;
          arc_d = (arc_full > {{(TblW-ArcW){1'b0}}, ARC_MAX}) ? ARC_MAX : arc_full[ArcW-1:0];
        end
        state_d = S_RMS1;
      end
      S_RMS1: begin
        op_a_d  = $signed({1'b0, rms_q}) - $signed({1'b0, attn_q});
        op_b_d  = $signed({1'b0, (attn_q > rms_q) ? atk_coef_q : rel_coef_cfg_q});
        state_d = S_MUL2;
      end
      S_MUL2: begin
        state_d = S_RMS2;
      end
      S_RMS2: begin
        // wait here while the previous result is still held
        if (out_free) begin
          rms_d       = env_clamp;
          out_valid_d = 1'b1;
          out_data_d  = attn_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      prev_attn_q    <= '0;
      rms_q          <= '0;
      arc_q          <= '0;
      rcoef_q        <= $signed(COEF_MAX);
      rel_q          <= 1'b0;
      out_valid_q    <= 1'b0;
      atk_coef_q     <= FULL31;
      rel_coef_cfg_q <= FULL31;
    end else begin
      state_q     <= state_d;
      prev_attn_q <= prev_attn_d;
      rms_q       <= rms_d;
      arc_q       <= arc_d;
      rcoef_q     <= rcoef_d;
      rel_q       <= rel_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_RMS_ATTACK:  atk_coef_q     <= cfg_data_i;
          CFG_RMS_RELEASE: rel_coef_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    attn_q     <= attn_d;
    op_a_q     <= op_a_d;
    op_b_q     <= op_b_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o     = out_valid_q;
  assign smoothed_attn_o = out_data_q;

endmodule

`default_nettype wire
